>>> rtl/gbn_sw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_pkg
// Shared widths, codes and window helpers for the Go-Back-N sender window.
// ----------------------------------------------------------------------------
package gbn_sw_pkg;

    localparam int SEQ_W  = 16;
    localparam int TICK_W = 32;
    localparam int OFF_W  = 32;
    localparam int LEN_W  = 16;
    localparam int WIN_W  = 7;
    localparam int ACK_W  = 32;
    localparam int KIND_W = 2;
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    typedef logic [SEQ_W-1:0] seq_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_TICK    = 2'd0,
        KIND_SERVICE = 2'd1,
        KIND_ACK     = 2'd2
    } kind_t;

    typedef enum logic [CFG_AW-1:0] {
        REG_WINDOW_SIZE   = 3'd0,
        REG_TOTAL_PACKETS = 3'd1,
        REG_SEGMENT_SIZE  = 3'd2,
        REG_LAST_LENGTH   = 3'd3,
        REG_TIMEOUT_TICKS = 3'd4
    } cfg_reg_t;

    // last sequence number; zero packets acts as one
    function automatic seq_t calc_last(input logic [CFG_DW-1:0] total);
        return (total == '0) ? '0 : seq_t'(total - 1'b1);
    endfunction

    // window top, clamped to the last packet
    function automatic seq_t calc_top(input seq_t base, input logic [WIN_W-1:0] eff,
                                      input seq_t lastp);
        logic [SEQ_W:0] sum;
        sum = {1'b0, base} + (SEQ_W+1)'(eff) - 1'b1;
        if (sum > {1'b0, lastp})
        begin
            return lastp;
        end
        return sum[SEQ_W-1:0];
    endfunction

endpackage

>>> rtl/gbn_sw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbn_sw_if
// Valid/ready channels for the sender window: event beats in, result beats out.
// ----------------------------------------------------------------------------
interface gbn_sw_item_if;
    import gbn_sw_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ACK_W-1:0]  ack_seq;

    modport source (output valid, kind, ack_seq, input ready);
    modport sink   (input valid, kind, ack_seq, output ready);
endinterface

interface gbn_sw_result_if;
    import gbn_sw_pkg::*;

    logic             valid;
    logic             ready;
    logic             send_valid;
    logic [SEQ_W-1:0] send_seq;
    logic [OFF_W-1:0] send_offset;
    logic [LEN_W-1:0] send_length;
    logic             timed_out;
    logic [SEQ_W-1:0] rewind_seq;
    logic             end_marker;
    logic             transfer_done;

    modport source (output valid, send_valid, send_seq, send_offset, send_length,
                    timed_out, rewind_seq, end_marker, transfer_done, input ready);
    modport sink   (input valid, send_valid, send_seq, send_offset, send_length,
                    timed_out, rewind_seq, end_marker, transfer_done, output ready);
endinterface

>>> rtl/go_back_n_sender_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// go_back_n_sender_window_core
// Go-Back-N sender window: issues packets, tracks acks, detects timeouts.
// ----------------------------------------------------------------------------
// Takes one event beat per cycle while the result side is ready and returns one
// result beat for each, via the input stage and result registers. The window
// state update reads the base packet's send stamp from a MAX_WINDOW x 32
// store, prefetched into a read register at the next base slot. The stamp
// store has one valid bit per entry, cleared at reset, so no clearing pass is
// needed. The user must make configuration writes only while no beat is in
// flight; the block does not enforce it. An event may follow from the next cycle on.
// ----------------------------------------------------------------------------
module go_back_n_sender_window_core #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [gbn_sw_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [gbn_sw_pkg::CFG_DW-1:0] cfg_wdata,
    gbn_sw_item_if.sink                   item,
    gbn_sw_result_if.source               result
);
    import gbn_sw_pkg::*;

    localparam int IDX_W    = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int WIN_CAP  = (MAX_WINDOW < 127) ? MAX_WINDOW : 127;
    localparam int RED_W    = SEQ_W + 1;
    localparam int RECIP_SH = RED_W;
    localparam int RECIP_W  = RED_W + 1;
    localparam int PROD_W   = RED_W + RECIP_W;
    localparam int RECIP    = (1 << RECIP_SH) / MAX_WINDOW;

    localparam logic [RECIP_W-1:0] RECIP_K  = RECIP_W'(RECIP);
    localparam logic [RED_W-1:0]   WIN_MOD  = RED_W'(MAX_WINDOW);
    localparam logic [IDX_W-1:0]   IDX_LAST = IDX_W'(MAX_WINDOW - 1);

    // x mod MAX_WINDOW from a quotient estimate that is low by at most one
    function automatic logic [IDX_W-1:0] mod_fix(input logic [RED_W-1:0] x,
                                                 input logic [RED_W-1:0] q);
        logic [2*RED_W-1:0] qw;
        logic [RED_W-1:0]   r;
        qw = q * WIN_MOD;
        r  = x - qw[RED_W-1:0];
        if (r >= WIN_MOD)
        begin
            r = r - WIN_MOD;
        end
        return r[IDX_W-1:0];
    endfunction

    function automatic logic [WIN_W-1:0] eff_of(input logic [WIN_W-1:0] w);
        if (w == '0)
        begin
            return WIN_W'(1);
        end
        if (int'(w) > WIN_CAP)
        begin
            return WIN_W'(WIN_CAP);
        end
        return w;
    endfunction

    // configuration
    logic [WIN_W-1:0]  ws_reg, ws_next;
    logic [CFG_DW-1:0] tp_reg, tp_next;
    logic [LEN_W-1:0]  seg_reg, seg_next;
    logic [LEN_W-1:0]  last_len_reg, last_len_next;
    logic [CFG_DW-1:0] tmo_reg, tmo_next;

    // window state
    seq_t              next_seq_reg, next_seq_next;
    seq_t              base_reg, base_next;
    seq_t              top_reg, top_next;
    logic              done_reg, done_next;
    logic [TICK_W-1:0] tick_reg, tick_next;
    logic [IDX_W-1:0]  next_idx_reg, next_idx_next;
    logic [IDX_W-1:0]  base_idx_reg, base_idx_next;
    logic [RED_W-1:0]  lq_reg;

    // input stage
    logic              in_valid_reg;
    logic [KIND_W-1:0] kind_reg;
    logic [ACK_W-1:0]  ack_reg;
    logic [RED_W-1:0]  ackq_reg;

    // stamp store
    logic [TICK_W-1:0]     mem [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] vld_reg;
    logic [TICK_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic                  wr_en;
    logic [IDX_W-1:0]      wr_idx;
    logic [TICK_W-1:0]     wr_data;

    // result register
    logic             out_valid_reg;
    logic             res_sv_reg, res_sv_next;
    seq_t             res_seq_reg, res_seq_next;
    logic [OFF_W-1:0] res_off_reg, res_off_next;
    logic [LEN_W-1:0] res_len_reg, res_len_next;
    logic             res_tout_reg, res_tout_next;
    seq_t             res_rseq_reg, res_rseq_next;
    logic             res_end_reg, res_end_next;
    logic             res_done_reg, res_done_next;

    logic              proc_fire;
    logic              item_fire;
    seq_t              lastp;
    logic [IDX_W-1:0]  lastp_idx;
    logic [WIN_W-1:0]  eff;
    logic [RED_W-1:0]  item_x;
    logic [PROD_W-1:0] item_prod;
    logic [RED_W-1:0]  ack_x;
    logic [IDX_W-1:0]  ack_idx;
    logic [PROD_W-1:0] lq_prod;
    logic [OFF_W-1:0]  off_prod;
    logic [TICK_W-1:0] stamp_pref;
    logic [TICK_W-1:0] stamp;
    logic [TICK_W-1:0] age;
    logic              issue;
    seq_t              ack_b;

    assign proc_fire   = in_valid_reg && (!out_valid_reg || result.ready);
    assign item.ready  = !in_valid_reg || proc_fire;
    assign item_fire   = item.valid && item.ready;

    assign lastp       = calc_last(tp_reg);
    assign eff         = eff_of(ws_reg);
    assign lq_prod     = PROD_W'({1'b0, lastp}) * PROD_W'(RECIP_K);
    assign lastp_idx   = mod_fix({1'b0, lastp}, lq_reg);

    assign item_x      = RED_W'(item.ack_seq[SEQ_W-1:0]) + 1'b1;
    assign item_prod   = PROD_W'(item_x) * PROD_W'(RECIP_K);
    assign ack_x       = RED_W'(ack_reg[SEQ_W-1:0]) + 1'b1;
    assign ack_idx     = mod_fix(ack_x, ackq_reg);
    assign ack_b       = ack_reg[SEQ_W-1:0] + 1'b1;

    assign off_prod    = OFF_W'(next_seq_reg) * OFF_W'(seg_reg);
    assign stamp_pref  = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        ws_next       = ws_reg;
        tp_next       = tp_reg;
        seg_next      = seg_reg;
        last_len_next = last_len_reg;
        tmo_next      = tmo_reg;
        next_seq_next = next_seq_reg;
        base_next     = base_reg;
        top_next      = top_reg;
        done_next     = done_reg;
        tick_next     = tick_reg;
        next_idx_next = next_idx_reg;
        base_idx_next = base_idx_reg;
        wr_en         = 1'b0;
        wr_idx        = next_idx_reg;
        wr_data       = tick_reg;
        res_sv_next   = 1'b0;
        res_seq_next  = '0;
        res_off_next  = '0;
        res_len_next  = '0;
        res_tout_next = 1'b0;
        res_rseq_next = '0;
        res_end_next  = 1'b0;
        issue         = 1'b0;
        stamp         = stamp_pref;
        age           = '0;

        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_WINDOW_SIZE:
                begin
                    ws_next  = cfg_wdata[WIN_W-1:0];
                    top_next = calc_top(base_reg, eff_of(cfg_wdata[WIN_W-1:0]), lastp);
                end
                REG_TOTAL_PACKETS:
                begin
                    tp_next  = cfg_wdata;
                    top_next = calc_top(base_reg, eff, calc_last(cfg_wdata));
                end
                REG_SEGMENT_SIZE:  seg_next      = cfg_wdata;
                REG_LAST_LENGTH:   last_len_next = cfg_wdata;
                REG_TIMEOUT_TICKS: tmo_next      = cfg_wdata;
                default: ;
            endcase
        end

        if (proc_fire)
        begin
            unique case (kind_t'(kind_reg))
                KIND_TICK:
                begin
                    tick_next = tick_reg + 1'b1;
                end
                KIND_SERVICE, KIND_ACK:
                begin
                    if (!done_reg)
                    begin
                        issue = (next_seq_reg <= top_reg) && (next_seq_reg <= lastp);
                        if (issue)
                        begin
                            res_sv_next   = 1'b1;
                            res_seq_next  = next_seq_reg;
                            res_off_next  = off_prod;
                            res_len_next  = (next_seq_reg == lastp) ? last_len_reg : seg_reg;
                            wr_en         = 1'b1;
                            next_seq_next = next_seq_reg + 1'b1;
                            next_idx_next = (next_idx_reg == IDX_LAST) ? '0
                                                                       : next_idx_reg + 1'b1;
                        end
                        if ((kind_t'(kind_reg) == KIND_ACK) && (ack_reg >= ACK_W'(base_reg)))
                        begin
                            if (ack_reg >= ACK_W'(lastp))
                            begin
                                base_next     = lastp;
                                base_idx_next = lastp_idx;
                                top_next      = lastp;
                                done_next     = 1'b1;
                                res_end_next  = 1'b1;
                            end
                            else
                            begin
                                base_next     = ack_b;
                                base_idx_next = ack_idx;
                                top_next      = calc_top(ack_b, eff, lastp);
                            end
                        end
                        else
                        begin
                            // same-step issue into the base slot overrides the prefetch
                            if (issue && (next_idx_reg == base_idx_reg))
                            begin
                                stamp = tick_reg;
                            end
                            age = tick_reg - stamp;
                            if (age > TICK_W'(tmo_reg))
                            begin
                                res_tout_next = 1'b1;
                                res_rseq_next = base_reg;
                                next_seq_next = base_reg;
                                next_idx_next = base_idx_reg;
                            end
                        end
                    end
                end
                default: ;
            endcase
        end

        res_done_next = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= WIN_W'(4);
            tp_reg        <= CFG_DW'(1);
            seg_reg       <= LEN_W'(1024);
            last_len_reg  <= LEN_W'(1024);
            tmo_reg       <= CFG_DW'(1);
            next_seq_reg  <= '0;
            base_reg      <= '0;
            top_reg       <= seq_t'(4 - 1);
            done_reg      <= 1'b0;
            tick_reg      <= '0;
            next_idx_reg  <= '0;
            base_idx_reg  <= '0;
            lq_reg        <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            vld_reg       <= '0;
            rd_valid_reg  <= 1'b0;
        end
        else
        begin
            ws_reg       <= ws_next;
            tp_reg       <= tp_next;
            seg_reg      <= seg_next;
            last_len_reg <= last_len_next;
            tmo_reg      <= tmo_next;
            next_seq_reg <= next_seq_next;
            base_reg     <= base_next;
            top_reg      <= top_next;
            done_reg     <= done_next;
            tick_reg     <= tick_next;
            next_idx_reg <= next_idx_next;
            base_idx_reg <= base_idx_next;
            lq_reg       <= lq_prod[RECIP_SH +: RED_W];
            rd_valid_reg <= (wr_en && (wr_idx == base_idx_next)) || vld_reg[base_idx_next];
            if (wr_en)
            begin
                vld_reg[wr_idx] <= 1'b1;
            end
            if (item_fire)
            begin
                in_valid_reg <= 1'b1;
            end
            else if (proc_fire)
            begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            kind_reg <= item.kind;
            ack_reg  <= item.ack_seq;
            ackq_reg <= item_prod[RECIP_SH +: RED_W];
        end
        if (proc_fire)
        begin
            res_sv_reg   <= res_sv_next;
            res_seq_reg  <= res_seq_next;
            res_off_reg  <= res_off_next;
            res_len_reg  <= res_len_next;
            res_tout_reg <= res_tout_next;
            res_rseq_reg <= res_rseq_next;
            res_end_reg  <= res_end_next;
            res_done_reg <= res_done_next;
        end
    end

    // stamp store, read ahead into a register at the next base slot
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && (wr_idx == base_idx_next))
        begin
            rd_data_reg <= wr_data;
        end
        else
        begin
            rd_data_reg <= mem[base_idx_next];
        end
    end

    assign result.valid         = out_valid_reg;
    assign result.send_valid    = res_sv_reg;
    assign result.send_seq      = res_seq_reg;
    assign result.send_offset   = res_off_reg;
    assign result.send_length   = res_len_reg;
    assign result.timed_out     = res_tout_reg;
    assign result.rewind_seq    = res_rseq_reg;
    assign result.end_marker    = res_end_reg;
    assign result.transfer_done = res_done_reg;

    a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> done_reg)
        else $error("transfer done flag dropped");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        (next_idx_reg <= IDX_LAST) && (base_idx_reg <= IDX_LAST))
        else $error("stamp slot index out of range");

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !result.ready) |-> !item.ready)
        else $error("beat accepted while pipeline is stalled");

    a_end_done: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_fire && res_end_next) |=> done_reg && result.transfer_done)
        else $error("end marker without transfer done");

endmodule

>>> sim/tb_go_back_n_sender_window_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_go_back_n_sender_window_core
// Self-checking bench for the Go-Back-N sender window core.
// Event beats (ticks, service steps, acks, unused kind codes) go in over the
// item channel. The bench keeps its own copy of the window, the send stamps
// and the registers, works out the result of every accepted beat, and checks
// the result beats in order, field by field. Directed steps cover the reset
// state, register extremes, rewinds, stale and early acks and a base that was
// never sent. Random traffic then runs under several settings and idle
// patterns, with one long result-side hold. The run ends with the final ack
// and service after done.
// ----------------------------------------------------------------------------
module tb_go_back_n_sender_window_core;
    import gbn_sw_pkg::*;

    localparam int         STAMP_DEPTH    = 64;
    localparam int         WATCHDOG_LIMIT = 4000;
    localparam int         HOLD_CYCLES    = 300;
    localparam int         PHASE_EVENTS   = 200;
    localparam logic [1:0] KIND_IGNORED   = 2'd3;

    typedef struct packed {
        logic             send_valid;
        seq_t             send_seq;
        logic [OFF_W-1:0] send_offset;
        logic [LEN_W-1:0] send_length;
        logic             timed_out;
        seq_t             rewind_seq;
        logic             end_marker;
        logic             transfer_done;
    } window_out_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    gbn_sw_item_if   item ();
    gbn_sw_result_if result ();

    go_back_n_sender_window_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .result    (result)
    );

    // window model
    logic [WIN_W-1:0]  wnd_cfg;
    logic [15:0]       total_cfg;
    logic [15:0]       seg_cfg;
    logic [15:0]       last_len_cfg;
    logic [15:0]       tmo_cfg;
    seq_t              pk_next;
    seq_t              pk_base;
    seq_t              pk_top;
    logic              pk_done;
    logic [TICK_W-1:0] tick_now;
    logic [TICK_W-1:0] stamp_mem [STAMP_DEPTH];

    window_out_t window_outcomes [$];
    window_out_t due_out;

    int fail_count;
    int n_events;
    int n_results;
    int n_issued;
    int n_rewinds;
    int n_ends;
    int idle_cycles;
    int tx_idle_pct;
    int rx_stall_pct;
    int rx_hold_req;
    int rx_hold_done;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic logic [31:0] eff_window();
        if (wnd_cfg == '0)
        begin
            return 32'd1;
        end
        if (wnd_cfg > STAMP_DEPTH)
        begin
            return STAMP_DEPTH;
        end
        return 32'(wnd_cfg);
    endfunction

    function automatic logic [31:0] last_index();
        return (total_cfg == '0) ? 32'd0 : 32'(total_cfg) - 32'd1;
    endfunction

    function automatic void clamp_top();
        logic [31:0] top;
        top = 32'(pk_base) + eff_window() - 32'd1;
        if (top > last_index())
        begin
            top = last_index();
        end
        pk_top = top[SEQ_W-1:0];
    endfunction

    function automatic window_out_t advance_window(input logic [1:0] k, input logic [31:0] ack);
        window_out_t r;
        logic [31:0] lastp;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] age;
        r = '0;
        lastp = last_index();
        if (k == KIND_TICK)
        begin
            tick_now = tick_now + 1'b1;
        end
        else if ((k == KIND_SERVICE || k == KIND_ACK) && !pk_done)
        begin
            if (pk_next <= pk_top && 32'(pk_next) <= lastp)
            begin
                r.send_valid  = 1'b1;
                r.send_seq    = pk_next;
                r.send_offset = 32'(pk_next) * 32'(seg_cfg);
                r.send_length = (32'(pk_next) == lastp) ? last_len_cfg : seg_cfg;
                stamp_mem[pk_next % STAMP_DEPTH] = tick_now;
                pk_next = pk_next + 1'b1;
            end
            if (k == KIND_ACK && ack >= 32'(pk_base))
            begin
                a = (ack > lastp) ? lastp : ack;
                b = a + 32'd1;
                if (b > lastp)
                begin
                    b = lastp;
                end
                pk_base = b[SEQ_W-1:0];
                clamp_top();
                if (a == lastp)
                begin
                    pk_done      = 1'b1;
                    r.end_marker = 1'b1;
                end
            end
            else
            begin
                age = tick_now - stamp_mem[pk_base % STAMP_DEPTH];
                if (age > 32'(tmo_cfg))
                begin
                    r.timed_out  = 1'b1;
                    r.rewind_seq = pk_base;
                    pk_next      = pk_base;
                end
            end
        end
        r.transfer_done = pk_done;
        return r;
    endfunction

    task automatic report_mismatch(input string what);
        fail_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
        begin
            report_mismatch($sformatf("result %0d %s got 0x%0h want 0x%0h",
                                      n_results, name, got, want));
        end
    endtask

    // result side: random stall, plus a counted hold when one is requested
    initial
    begin
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_done < rx_hold_req)
            begin
                result.ready <= 1'b0;
                rx_hold_done++;
            end
            else
            begin
                result.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && result.valid === 1'b1 && result.ready === 1'b1)
        begin
            if (window_outcomes.size() == 0)
            begin
                report_mismatch("result beat with nothing outstanding");
            end
            else
            begin
                due_out = window_outcomes.pop_front();
                check_field("send_valid", 32'(result.send_valid), 32'(due_out.send_valid));
                check_field("send_seq", 32'(result.send_seq), 32'(due_out.send_seq));
                check_field("send_offset", result.send_offset, due_out.send_offset);
                check_field("send_length", 32'(result.send_length), 32'(due_out.send_length));
                check_field("timed_out", 32'(result.timed_out), 32'(due_out.timed_out));
                check_field("rewind_seq", 32'(result.rewind_seq), 32'(due_out.rewind_seq));
                check_field("end_marker", 32'(result.end_marker), 32'(due_out.end_marker));
                check_field("transfer_done", 32'(result.transfer_done),
                            32'(due_out.transfer_done));
                n_issued  += due_out.send_valid;
                n_rewinds += due_out.timed_out;
                n_ends    += due_out.end_marker;
            end
            n_results++;
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (rst_n !== 1'b1 || (item.valid === 1'b1 && item.ready === 1'b1)
                || (result.valid === 1'b1 && result.ready === 1'b1))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $display("watchdog: no beat moved for %0d cycles, %0d results outstanding",
                 WATCHDOG_LIMIT, window_outcomes.size());
        $display("FAILURE");
        $finish;
    end

    task automatic send_event(input logic [1:0] k, input logic [31:0] ack);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item.valid <= 1'b0;
            @(posedge clk);
        end
        item.valid   <= 1'b1;
        item.kind    <= k;
        item.ack_seq <= ack;
        @(posedge clk);
        while (item.ready !== 1'b1)
        begin
            @(posedge clk);
        end
        window_outcomes.push_back(advance_window(k, ack));
        n_events++;
    endtask

    task automatic wait_drained();
        item.valid <= 1'b0;
        while (window_outcomes.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW_SIZE:
            begin
                wnd_cfg = val[WIN_W-1:0];
                clamp_top();
            end
            REG_TOTAL_PACKETS:
            begin
                total_cfg = val;
                clamp_top();
            end
            REG_SEGMENT_SIZE:  seg_cfg = val;
            REG_LAST_LENGTH:   last_len_cfg = val;
            REG_TIMEOUT_TICKS: tmo_cfg = val;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // ticks, services and acks (inside the sent range, some early, some stale), some unused codes
    task automatic pick_event(output logic [1:0] k, output logic [31:0] ack);
        int          roll;
        logic [31:0] hi;
        roll = $urandom_range(99);
        k    = KIND_SERVICE;
        ack  = $urandom();
        if (roll < 25)
        begin
            k = KIND_TICK;
        end
        else if (roll < 50)
        begin
            k = KIND_SERVICE;
        end
        else if (roll < 75)
        begin
            k   = KIND_ACK;
            hi  = (pk_next > pk_base) ? 32'(pk_next) - 32'd1 : 32'(pk_base);
            ack = $urandom_range(hi, 32'(pk_base));
        end
        else if (roll < 85)
        begin
            k   = KIND_ACK;
            ack = 32'(pk_base) + $urandom_range(eff_window() + 2);
        end
        else if (roll < 94)
        begin
            if (pk_base != '0)
            begin
                k   = KIND_ACK;
                ack = $urandom_range(32'(pk_base) - 32'd1);
            end
        end
        else
        begin
            k = KIND_IGNORED;
        end
    endtask

    task automatic test_reset_state();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        send_event(KIND_IGNORED, 32'hFFFF_FFFF);
        send_event(KIND_SERVICE, 32'h0);
        send_event(KIND_TICK, 32'h0);
        send_event(KIND_TICK, 32'h0);
        send_event(KIND_SERVICE, 32'h0);
        wait_drained();
        write_reg(REG_TOTAL_PACKETS, 16'd0);
        send_event(KIND_SERVICE, 32'h0);
        wait_drained();
    endtask

    task automatic test_register_extremes();
        write_reg(REG_TOTAL_PACKETS, 16'hFFFF);
        write_reg(REG_WINDOW_SIZE, 16'd0);
        write_reg(REG_SEGMENT_SIZE, 16'hFFFF);
        write_reg(REG_LAST_LENGTH, 16'hFFFF);
        write_reg(REG_TIMEOUT_TICKS, 16'd0);
        send_event(KIND_SERVICE, 32'h0);
        send_event(KIND_ACK, 32'd0);
        send_event(KIND_SERVICE, 32'h0);
        send_event(KIND_ACK, 32'd0);
        send_event(KIND_TICK, 32'h0);
        send_event(KIND_SERVICE, 32'h0);
        wait_drained();
        write_reg(REG_WINDOW_SIZE, 16'd127);
        // ack well past what was sent: new base has never been stamped
        send_event(KIND_ACK, 32'd40);
        send_event(KIND_TICK, 32'h0);
        send_event(KIND_TICK, 32'h0);
        send_event(KIND_SERVICE, 32'h0);
        send_event(KIND_SERVICE, 32'h0);
        wait_drained();
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        send_event(KIND_TICK, 32'h0);
        send_event(KIND_SERVICE, 32'h0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int          wnd_set  [6] = '{1, 64, 127, 8, 3, 33};
        int          seg_set  [6] = '{1, 65535, 1000, 1460, 512, 17};
        int          last_set [6] = '{1, 65535, 7, 500, 65535, 1};
        int          tmo_set  [6] = '{0, 65535, 5, 2, 20, 1};
        int          tx_set   [4] = '{0, 60, 0, 17};
        int          rx_set   [4] = '{0, 0, 60, 17};
        int          sent;
        logic [1:0]  k;
        logic [31:0] ack;
        for (int p = 0; p < 6; p++)
        begin
            wait_drained();
            write_reg(REG_WINDOW_SIZE, 16'(wnd_set[p]));
            write_reg(REG_SEGMENT_SIZE, 16'(seg_set[p]));
            write_reg(REG_LAST_LENGTH, 16'(last_set[p]));
            write_reg(REG_TIMEOUT_TICKS, 16'(tmo_set[p]));
            tx_idle_pct  = tx_set[p % 4];
            rx_stall_pct = rx_set[p % 4];
            sent = 0;
            while (sent < PHASE_EVENTS)
            begin
                pick_event(k, ack);
                send_event(k, ack);
                if (k != KIND_IGNORED)
                begin
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_input_backpressure();
        logic [1:0]  k;
        logic [31:0] ack;
        wait_drained();
        write_reg(REG_WINDOW_SIZE, 16'd16);
        write_reg(REG_TIMEOUT_TICKS, 16'd4);
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req += HOLD_CYCLES;
        repeat (80)
        begin
            pick_event(k, ack);
            send_event(k, ack);
        end
        wait_drained();
    endtask

    task automatic test_transfer_end();
        seq_t final_seq;
        wait_drained();
        tx_idle_pct  = 17;
        rx_stall_pct = 17;
        final_seq = (pk_next > pk_base) ? pk_next : pk_base;
        write_reg(REG_WINDOW_SIZE, 16'd64);
        write_reg(REG_TIMEOUT_TICKS, 16'hFFFF);
        write_reg(REG_LAST_LENGTH, 16'd77);
        write_reg(REG_TOTAL_PACKETS, 16'(final_seq) + 16'd1);
        for (int i = 0; i < 70; i++)
        begin
            if (!(pk_next <= pk_top && 32'(pk_next) <= last_index()))
            begin
                break;
            end
            send_event(KIND_SERVICE, 32'h0);
        end
        if (32'(pk_base) < last_index())
        begin
            send_event(KIND_ACK, 32'(pk_base));
        end
        send_event(KIND_SERVICE, 32'h0);
        // ack beyond the end closes the transfer
        send_event(KIND_ACK, 32'hFFFF_FFFF);
        send_event(KIND_SERVICE, 32'h0);
        send_event(KIND_ACK, 32'd3);
        send_event(KIND_TICK, 32'h0);
        send_event(KIND_IGNORED, 32'h5A5A_A5A5);
        wait_drained();
    endtask

    initial
    begin
        fail_count   = 0;
        n_events     = 0;
        n_results    = 0;
        n_issued     = 0;
        n_rewinds    = 0;
        n_ends       = 0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 0;
        rx_hold_done = 0;
        wnd_cfg      = 7'd4;
        total_cfg    = 16'd1;
        seg_cfg      = 16'd1024;
        last_len_cfg = 16'd1024;
        tmo_cfg      = 16'd1;
        pk_next      = '0;
        pk_base      = '0;
        pk_top       = seq_t'(3);
        pk_done      = 1'b0;
        tick_now     = '0;
        foreach (stamp_mem[i])
        begin
            stamp_mem[i] = '0;
        end
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_addr     <= '0;
        cfg_wdata    <= '0;
        item.valid   <= 1'b0;
        item.kind    <= KIND_TICK;
        item.ack_seq <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_state();
        test_register_extremes();
        test_random_traffic();
        test_input_backpressure();
        test_transfer_end();

        repeat (10) @(posedge clk);
        $display("Covered %0d event beats and %0d result beats:", n_events, n_results);
        $display("%0d sends, %0d rewinds, %0d end markers; windows 0..127,",
                 n_issued, n_rewinds, n_ends);
        $display("timeouts 0..65535, idle/stall mixes and a %0d-cycle result hold.",
                 HOLD_CYCLES);
        if (fail_count == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("%0d mismatches", fail_count);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
